FILE: src/scfd_pkg.sv
// ----------------------------------------------------------------------------
// scfd_pkg
// Shared types and constants for the checksum-framed byte deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package scfd_pkg;

  localparam logic [7:0] START_BYTE      = 8'hEE;
  localparam logic [7:0] MAX_LEN_RESET   = 8'hFF;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_END    = 2'd2
  } kind_t;

  typedef enum logic [4:0] {
    PH_HUNT = 5'b00001,
    PH_CMD  = 5'b00010,
    PH_LEN  = 5'b00100,
    PH_DATA = 5'b01000,
    PH_CHK  = 5'b10000
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] command;
    logic [7:0] payload_length;
    logic [7:0] data_byte;
    logic       checksum_ok;
  } scfd_result_t;

endpackage

`default_nettype wire

FILE: src/sum_checked_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// sum_checked_frame_deframer_top
// Byte-stream deframer for start-byte / command / length / payload / checksum
// frames with an 8-bit additive checksum.
// ----------------------------------------------------------------------------
// Takes one received byte per clock on the in_ channel and gives header,
// payload and frame-end results on the out_ channel. Each byte passes an input
// register and, if it produces a result, a result register; a new byte is
// accepted every cycle as long as the result register is free or being
// drained. Bytes that give no result (hunting, command byte, dropped oversize
// length) never wait on the out_ side. cfg_wdata sets the largest accepted
// payload length (reset 255); write it only while idle.
`default_nettype none

module sum_checked_frame_deframer_top
  import scfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_command,
  output logic [7:0]      out_payload_length,
  output logic [7:0]      out_data_byte,
  output logic            out_checksum_ok
);

  logic [7:0]   max_len_r;
  logic         s1_valid_r, s1_valid_nxt;
  logic [7:0]   s1_byte_r;
  logic         out_valid_r, out_valid_nxt;
  scfd_result_t out_res_r;
  scfd_result_t res;
  logic         res_valid;
  logic         out_free;
  logic         s1_adv;
  logic         in_xfer;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  scfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .rx_byte   (s1_byte_r),
    .max_len   (max_len_r),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && (!res_valid || out_free);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (s1_adv && res_valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_rx_byte;
    end
    if (s1_adv && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_res_r.kind;
  assign out_command        = out_res_r.command;
  assign out_payload_length = out_res_r.payload_length;
  assign out_data_byte      = out_res_r.data_byte;
  assign out_checksum_ok    = out_res_r.checksum_ok;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.kind != KIND_DATA) |-> (out_res_r.data_byte == 8'd0))
    else $error("data byte set outside payload transfer");

  a_ok_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.kind != KIND_END) |-> !out_res_r.checksum_ok)
    else $error("checksum flag set outside frame end");

  a_header_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.kind == KIND_HEADER)
      |-> (out_res_r.payload_length <= max_len_r))
    else $error("header with oversize length");

endmodule

`default_nettype wire

FILE: src/scfd_parser.sv
// ----------------------------------------------------------------------------
// scfd_parser
// Frame state machine: hunts for the start byte, tracks header, payload and
// checksum, and forms the result for the byte at its input.
// ----------------------------------------------------------------------------
`default_nettype none

module scfd_parser
  import scfd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step,
  input  wire logic [7:0]   rx_byte,
  input  wire logic [7:0]   max_len,
  output logic              res_valid,
  output scfd_result_t      res
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] left_dec;
  logic [7:0] sum_add;

  assign left_dec = left_r - 8'd1;
  assign sum_add  = sum_r + rx_byte;

  always_comb begin
    phase_nxt         = phase_r;
    left_nxt          = left_r;
    sum_nxt           = sum_r;
    cmd_nxt           = cmd_r;
    len_nxt           = len_r;
    res_valid         = 1'b0;
    res.kind          = KIND_HEADER;
    res.command       = cmd_r;
    res.payload_length = len_r;
    res.data_byte     = 8'd0;
    res.checksum_ok   = 1'b0;
    unique case (phase_r)
      PH_HUNT: begin
        if (rx_byte == START_BYTE) begin
          sum_nxt   = START_BYTE;
          phase_nxt = PH_CMD;
        end
      end
      PH_CMD: begin
        cmd_nxt   = rx_byte;
        sum_nxt   = sum_add;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        sum_nxt = sum_add;
        if (rx_byte > max_len) begin
          phase_nxt = PH_HUNT;
        end else begin
          len_nxt            = rx_byte;
          left_nxt           = rx_byte;
          phase_nxt          = (rx_byte == 8'd0) ? PH_CHK : PH_DATA;
          res_valid          = 1'b1;
          res.kind           = KIND_HEADER;
          res.payload_length = rx_byte;
        end
      end
      PH_DATA: begin
        sum_nxt       = sum_add;
        left_nxt      = left_dec;
        if (left_dec == 8'd0) begin
          phase_nxt = PH_CHK;
        end
        res_valid     = 1'b1;
        res.kind      = KIND_DATA;
        res.data_byte = rx_byte;
      end
      PH_CHK: begin
        phase_nxt       = PH_HUNT;
        res_valid       = 1'b1;
        res.kind        = KIND_END;
        res.checksum_ok = (sum_r == rx_byte);
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      left_r  <= 8'd0;
      sum_r   <= 8'd0;
      cmd_r   <= 8'd0;
      len_r   <= 8'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      sum_r   <= sum_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

`default_nettype wire
